[design/tdssf_pkg.sv]
// Shared constants and helpers for the two-digit seven-segment formatter.
// Holds the glyph table, segment bit masks, opcode codes and a divide-by-ten helper.
// No dependencies.
package tdssf_pkg;

    localparam logic [1:0] OP_DEC = 2'd0;
    localparam logic [1:0] OP_FIX = 2'd1;
    localparam logic [1:0] OP_HEX = 2'd2;
    localparam logic [1:0] OP_BAD = 2'd3;

    localparam logic [7:0]  SEG_POINT = 8'h01;
    localparam logic [7:0]  SEG_MINUS = 8'h80;
    localparam logic [15:0] SEG_ERROR = {SEG_MINUS, SEG_MINUS};

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'h0: seg = 8'h7E;
            4'h1: seg = 8'h0A;
            4'h2: seg = 8'hB6;
            4'h3: seg = 8'h9E;
            4'h4: seg = 8'hCA;
            4'h5: seg = 8'hDC;
            4'h6: seg = 8'hFC;
            4'h7: seg = 8'h0E;
            4'h8: seg = 8'hFE;
            4'h9: seg = 8'hDE;
            4'hA: seg = 8'hEE;
            4'hB: seg = 8'hF8;
            4'hC: seg = 8'h74;
            4'hD: seg = 8'hBA;
            4'hE: seg = 8'hF4;
            default: seg = 8'hE4;
        endcase
        return seg;
    endfunction

    // Quotient in the high nibble, remainder in the low nibble; exact for 0..99.
    function automatic logic [7:0] div10(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = {8'd0, x} * 15'd205;
        q    = prod[14:11];
        r    = x - 7'({q, 3'b000} + {2'b00, q, 1'b0});
        return {q, r[3:0]};
    endfunction

endpackage

[design/tdssf_encode.sv]
// Combinational encoder: opcode and signed value to two digit segment bytes.
// Depends on tdssf_pkg for the glyph table, masks and divide-by-ten helper.
module tdssf_encode (
    input  logic [1:0]        opcode,
    input  logic signed [15:0] value,
    output logic [15:0]       pattern
);
    import tdssf_pkg::*;

    logic        neg;
    logic [16:0] ext;
    logic [16:0] mag;
    logic [16:0] u_sum;
    logic [12:0] u_mag;
    logic [14:0] t_sum;
    logic [10:0] t_mag;
    logic [7:0]  dec_qr;
    logic [7:0]  u_qr;
    logic [7:0]  t_qr;
    logic        u_bad;

    always_comb
    begin
        neg   = value[15];
        ext   = {value[15], value};
        mag   = neg ? (17'd0 - ext) : ext;
        // Round half away from zero on the magnitude: units and tenths.
        u_sum = mag + 17'd8;
        u_mag = u_sum[16:4];
        t_sum = {1'b0, mag[10:0], 3'b000} + {3'b000, mag[10:0], 1'b0} + 15'd8;
        t_mag = t_sum[14:4];
        dec_qr = div10(mag[6:0]);
        u_qr   = div10(u_mag[6:0]);
        t_qr   = div10(t_mag[6:0]);
        u_bad  = neg ? (u_mag > 13'd9) : (u_mag > 13'd99);

        case (opcode)
            OP_DEC:
            begin
                if (neg ? (mag > 17'd9) : (mag > 17'd99))
                    pattern = SEG_ERROR;
                else if (neg)
                    pattern = {SEG_MINUS, glyph(mag[3:0])};
                else
                    pattern = {glyph(dec_qr[7:4]), glyph(dec_qr[3:0])};
            end
            OP_HEX:
            begin
                if (neg ? (mag > 17'd15) : (mag > 17'd255))
                    pattern = SEG_ERROR;
                else if (neg)
                    pattern = {SEG_MINUS, glyph(mag[3:0])};
                else
                    pattern = {glyph(mag[7:4]), glyph(mag[3:0])};
            end
            OP_FIX:
            begin
                if (u_bad)
                    pattern = SEG_ERROR;
                else if (neg && (t_mag >= 11'd10))
                    pattern = {SEG_MINUS, glyph(u_mag[3:0]) | SEG_POINT};
                else if (neg && (t_mag != 11'd0))
                    pattern = {SEG_MINUS | SEG_POINT, glyph(t_mag[3:0])};
                else if (t_mag < 11'd100)
                    pattern = {glyph(t_qr[7:4]) | SEG_POINT, glyph(t_qr[3:0])};
                else
                    pattern = {glyph(u_qr[7:4]), glyph(u_qr[3:0]) | SEG_POINT};
            end
            default:
                pattern = SEG_ERROR;
        endcase
    end

endmodule

[design/two_digit_seven_segment_formatter.sv]
// Top level of the two-digit seven-segment formatter.
// Depends on tdssf_pkg and tdssf_encode.
//
// Usage:
//   Input channel item_valid/item_ready carries opcode and value; a transfer
//   happens on a rising edge with both high. Output channel
//   result_valid/result_ready carries segment_pattern (left digit in the high
//   byte, right digit in the low byte).
//   An input transfer loads the input register; the encoder logic then
//   feeds the result register, which loads when empty or draining.
//   Throughput: one item per cycle unless result_ready stalls; the encoder
//   is a single pass of table lookups and small constant divides between
//   the two registers. Every input produces exactly one result, in order.
//   Reset (rst_n low, asynchronous) empties both stages; item_ready is high
//   right after reset.
//   When the receiver stalls, the result register holds its word and one
//   more item waits in the input register; item_ready drops only when both
//   are full and result_ready is low.
module two_digit_seven_segment_formatter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         opcode,
    input  logic signed [15:0] value,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [15:0]        segment_pattern
);
    import tdssf_pkg::*;

    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic [1:0]         opcode_reg;
    logic signed [15:0] value_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    logic [15:0]        pattern_reg;
    logic [15:0]        enc_pattern;
    logic               advance;
    logic               take;

    tdssf_encode u_encode (
        .opcode  (opcode_reg),
        .value   (value_reg),
        .pattern (enc_pattern)
    );

    // Move the staged item on when the result register is empty or drains now.
    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = !stage_valid_reg || advance;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        stage_valid_next  = item_ready ? item_valid : stage_valid_reg;
        result_valid_next = advance ? stage_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            opcode_reg <= opcode;
            value_reg  <= value;
        end
        if (advance && stage_valid_reg)
            pattern_reg <= enc_pattern;
    end

    assign result_valid    = result_valid_reg;
    assign segment_pattern = pattern_reg;

    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (stage_valid_reg && result_valid_reg && !result_ready))
        else $error("item_ready low while pipeline has room");

    a_result_loads_encoding: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && advance) |=>
            (result_valid_reg && (pattern_reg == $past(enc_pattern))))
        else $error("result register did not capture the encoded item");

    a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=>
            (stage_valid_reg && $stable(value_reg) && $stable(opcode_reg)))
        else $error("staged item changed during a stall");

    a_bad_opcode_error: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && advance && (opcode_reg == OP_BAD)) |=>
            (pattern_reg == SEG_ERROR))
        else $error("unused opcode did not give the error pattern");

endmodule
